FILE: rtl/core/rds_pkg.sv
// shared constants, codes and controller/datapath interface types
// for the region depth statistics block; no dependencies
package rds_pkg;

	localparam int MAX_SAMPLES = 4096;
	localparam int ADDR_W      = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int SUM_W       = 28;
	localparam int Q_SHIFT     = 4;
	localparam int DIV_W       = SUM_W + Q_SHIFT;
	localparam int DIV_CNT_W   = $clog2(DIV_W);

	// configuration register indexes
	localparam logic [1:0] CFG_LOWER = 2'd0;
	localparam logic [1:0] CFG_UPPER = 2'd1;
	localparam logic [1:0] CFG_ALGO  = 2'd2;

	// statistic selection codes
	localparam logic [2:0] ALGO_MEDIAN = 3'd0;
	localparam logic [2:0] ALGO_MEAN   = 3'd1;
	localparam logic [2:0] ALGO_MIN    = 3'd2;
	localparam logic [2:0] ALGO_MAX    = 3'd3;
	localparam logic [2:0] ALGO_MODE   = 3'd4;

	typedef struct packed {
		logic take;
		logic div_init;
		logic div_step;
		logic scan_init;
		logic scan_step;
		logic med_init;
		logic med_bit;
		logic mode_init;
		logic mode_cand;
		logic mode_latch;
		logic mode_next;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic       div_done;
		logic       scan_end;
		logic       bit_last;
		logic       cand_last;
		logic       empty;
		logic [2:0] algo;
	} status_t;

endpackage

FILE: rtl/core/rds_datapath.sv
// datapath: config registers, sample store, running stats, serial divider,
// median bit search and mode count scan; uses rds_pkg
module rds_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [16:0]                cfg_data,
	input  logic [15:0]                depth_sample,
	input  rds_pkg::cmd_t              cmd,
	output rds_pkg::status_t           status,
	output logic                       result_valid,
	output logic [19:0]                chosen_depth,
	output logic [19:0]                mean_depth,
	output logic [15:0]                least_depth,
	output logic [15:0]                greatest_depth,
	output logic [rds_pkg::CNT_W-1:0]  kept_count,
	output logic                       overflowed
);

	logic [15:0] lower_q;
	logic [16:0] upper_q;
	logic [2:0]  algo_q;

	logic [rds_pkg::SUM_W-1:0] sum_q;
	logic [rds_pkg::CNT_W-1:0] count_q;
	logic [15:0]               min_q;
	logic [15:0]               max_q;
	logic                      drop_q;

	logic [rds_pkg::DIV_W-1:0]     quo_q;
	logic [rds_pkg::CNT_W-1:0]     rem_q;
	logic [rds_pkg::DIV_CNT_W-1:0] div_cnt_q;

	logic [rds_pkg::CNT_W-1:0]  scan_idx_q;
	logic [rds_pkg::CNT_W-1:0]  acc_q;
	logic                       hit_s1;
	logic [15:0]                rdata_s1;
	logic [3:0]                 bit_q;
	logic [15:0]                med_val_q;
	logic [rds_pkg::ADDR_W-1:0] cand_idx_q;
	logic [15:0]                cand_q;
	logic [15:0]                best_val_q;
	logic [rds_pkg::CNT_W-1:0]  best_cnt_q;

	logic [15:0] mem [rds_pkg::MAX_SAMPLES];

	logic                       in_range;
	logic                       full;
	logic                       store_en;
	logic [rds_pkg::ADDR_W-1:0] raddr;
	logic [rds_pkg::CNT_W:0]    trial;
	logic                       trial_ge;
	logic [15:0]                low_mask;
	logic [15:0]                med_test;
	logic                       match;
	logic                       keep_zero;
	logic [19:0]                chosen_d;

	assign in_range = (depth_sample > lower_q) && ({1'b0, depth_sample} < upper_q);
	assign full     = (count_q == rds_pkg::CNT_W'(rds_pkg::MAX_SAMPLES));
	assign store_en = cmd.take && in_range && !full;
	assign raddr    = cmd.mode_cand ? cand_idx_q : scan_idx_q[rds_pkg::ADDR_W-1:0];

	assign trial    = {rem_q, quo_q[rds_pkg::DIV_W-1]};
	assign trial_ge = (trial >= {1'b0, count_q});

	assign low_mask  = (16'd1 << bit_q) - 16'd1;
	assign med_test  = med_val_q | low_mask;
	assign match     = (algo_q == rds_pkg::ALGO_MODE) ? (rdata_s1 == cand_q)
		: (rdata_s1 <= med_test);
	assign keep_zero = (acc_q > (count_q >> 1));

	assign status.div_done  = (div_cnt_q == rds_pkg::DIV_CNT_W'(rds_pkg::DIV_W - 1));
	assign status.scan_end  = (scan_idx_q == count_q);
	assign status.bit_last  = (bit_q == 4'd0);
	assign status.cand_last = ({1'b0, cand_idx_q} == (count_q - 1'b1));
	assign status.empty     = (count_q == '0);
	assign status.algo      = algo_q;

	always_comb begin
		case (algo_q)
			rds_pkg::ALGO_MEAN: chosen_d = quo_q[19:0];
			rds_pkg::ALGO_MIN:  chosen_d = {min_q, 4'd0};
			rds_pkg::ALGO_MAX:  chosen_d = {max_q, 4'd0};
			rds_pkg::ALGO_MODE: chosen_d = {best_val_q, 4'd0};
			default:            chosen_d = {med_val_q, 4'd0};
		endcase
	end

	// sample store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (store_en) begin
			mem[count_q[rds_pkg::ADDR_W-1:0]] <= depth_sample;
		end
		rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= 16'd0;
			upper_q <= 17'd65535;
			algo_q  <= rds_pkg::ALGO_MEDIAN;
		end else if (cfg_we) begin
			case (cfg_index)
				rds_pkg::CFG_LOWER: lower_q <= cfg_data[15:0];
				rds_pkg::CFG_UPPER: upper_q <= cfg_data;
				rds_pkg::CFG_ALGO:  algo_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// running region statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			min_q   <= 16'hFFFF;
			max_q   <= 16'd0;
			drop_q  <= 1'b0;
		end else if (cmd.finish) begin
			sum_q   <= '0;
			count_q <= '0;
			min_q   <= 16'hFFFF;
			max_q   <= 16'd0;
			drop_q  <= 1'b0;
		end else if (cmd.take && in_range) begin
			if (full) begin
				drop_q <= 1'b1;
			end else begin
				sum_q   <= sum_q + {{(rds_pkg::SUM_W-16){1'b0}}, depth_sample};
				count_q <= count_q + 1'b1;
				if (depth_sample < min_q) min_q <= depth_sample;
				if (depth_sample > max_q) max_q <= depth_sample;
			end
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q     <= '0;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_init) begin
			quo_q     <= {sum_q, {rds_pkg::Q_SHIFT{1'b0}}};
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= trial_ge ? rds_pkg::CNT_W'(trial - {1'b0, count_q})
				: trial[rds_pkg::CNT_W-1:0];
			quo_q     <= {quo_q[rds_pkg::DIV_W-2:0], trial_ge};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	// store scan: address counter, read-valid flag, match counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			acc_q      <= '0;
			hit_s1     <= 1'b0;
		end else begin
			hit_s1 <= cmd.scan_step && (scan_idx_q != count_q);
			if (cmd.scan_init) begin
				scan_idx_q <= '0;
				acc_q      <= '0;
			end else begin
				if (cmd.scan_step && (scan_idx_q != count_q)) scan_idx_q <= scan_idx_q + 1'b1;
				if (hit_s1 && match) acc_q <= acc_q + 1'b1;
			end
		end
	end

	// median: settle one value bit per scan, msb first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q     <= 4'd15;
			med_val_q <= 16'd0;
		end else if (cmd.med_init) begin
			bit_q     <= 4'd15;
			med_val_q <= 16'd0;
		end else if (cmd.med_bit) begin
			if (!keep_zero) med_val_q <= med_val_q | (16'd1 << bit_q);
			bit_q <= bit_q - 4'd1;
		end
	end

	// mode: count each candidate, keep the most frequent, smallest on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_idx_q <= '0;
			cand_q     <= 16'd0;
			best_val_q <= 16'd0;
			best_cnt_q <= '0;
		end else if (cmd.mode_init) begin
			cand_idx_q <= '0;
			best_val_q <= 16'd0;
			best_cnt_q <= '0;
		end else begin
			if (cmd.mode_latch) cand_q <= rdata_s1;
			if (cmd.mode_next) begin
				if ((acc_q > best_cnt_q) || ((acc_q == best_cnt_q) && (cand_q < best_val_q))) begin
					best_cnt_q <= acc_q;
					best_val_q <= cand_q;
				end
				cand_idx_q <= cand_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			chosen_depth   <= status.empty ? 20'd0 : chosen_d;
			mean_depth     <= status.empty ? 20'd0 : quo_q[19:0];
			least_depth    <= status.empty ? 16'd0 : min_q;
			greatest_depth <= status.empty ? 16'd0 : max_q;
			kept_count     <= count_q;
			overflowed     <= drop_q;
		end
	end

endmodule

FILE: rtl/core/rds_ctrl.sv
// controller state machine sequencing sample intake, division and the
// median or mode scans; uses rds_pkg types
module rds_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             mode,
	input  rds_pkg::status_t status,
	output rds_pkg::cmd_t    cmd,
	output logic             busy
);

	typedef enum logic [9:0] {
		S_IDLE      = 10'b0000000001,
		S_DIV       = 10'b0000000010,
		S_CHOOSE    = 10'b0000000100,
		S_MED_SCAN  = 10'b0000001000,
		S_MED_BIT   = 10'b0000010000,
		S_MODE_CAND = 10'b0000100000,
		S_MODE_WAIT = 10'b0001000000,
		S_MODE_SCAN = 10'b0010000000,
		S_MODE_NEXT = 10'b0100000000,
		S_DONE      = 10'b1000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (mode) begin
						cmd.div_init = 1'b1;
						state_d      = S_DIV;
					end else begin
						cmd.take = 1'b1;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) state_d = S_CHOOSE;
			end
			S_CHOOSE: begin
				if (status.empty) begin
					state_d = S_DONE;
				end else begin
					case (status.algo)
						rds_pkg::ALGO_MEAN, rds_pkg::ALGO_MIN, rds_pkg::ALGO_MAX: begin
							state_d = S_DONE;
						end
						rds_pkg::ALGO_MODE: begin
							cmd.mode_init = 1'b1;
							state_d       = S_MODE_CAND;
						end
						default: begin
							cmd.med_init  = 1'b1;
							cmd.scan_init = 1'b1;
							state_d       = S_MED_SCAN;
						end
					endcase
				end
			end
			S_MED_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_end) state_d = S_MED_BIT;
			end
			S_MED_BIT: begin
				cmd.med_bit = 1'b1;
				if (status.bit_last) begin
					state_d = S_DONE;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_MED_SCAN;
				end
			end
			S_MODE_CAND: begin
				cmd.mode_cand = 1'b1;
				state_d       = S_MODE_WAIT;
			end
			S_MODE_WAIT: begin
				cmd.mode_latch = 1'b1;
				cmd.scan_init  = 1'b1;
				state_d        = S_MODE_SCAN;
			end
			S_MODE_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_end) state_d = S_MODE_NEXT;
			end
			S_MODE_NEXT: begin
				cmd.mode_next = 1'b1;
				state_d       = status.cand_last ? S_DONE : S_MODE_CAND;
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/core/region_depth_statistics.sv
// sample transaction: taken one per cycle back to back while busy is low, no result
// finish transaction: divider init, serial divider, statistic choice, store scans, done; result
// strobe the cycle after; no scan for mean/min/max or an empty region, one scan per value bit for median,
// one scan per kept sample for mode (one store read port); busy is high for the whole finish
// the receiver cannot stall: result_valid is a one-cycle strobe
// arst_n clears control and region state at once; the sample store has no reset
module region_depth_statistics (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [15:0] depth_sample,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data,
	// result strobe and fields
	output logic        result_valid,
	output logic [19:0] chosen_depth,
	output logic [19:0] mean_depth,
	output logic [15:0] least_depth,
	output logic [15:0] greatest_depth,
	output logic [12:0] kept_count,
	output logic        overflowed
);

	rds_pkg::cmd_t    cmd;
	rds_pkg::status_t status;

	// sequencer: intake in idle, then divide and optional store scans
	rds_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// store, running stats and the arithmetic behind each statistic
	rds_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.depth_sample   (depth_sample),
		.cmd            (cmd),
		.status         (status),
		.result_valid   (result_valid),
		.chosen_depth   (chosen_depth),
		.mean_depth     (mean_depth),
		.least_depth    (least_depth),
		.greatest_depth (greatest_depth),
		.kept_count     (kept_count),
		.overflowed     (overflowed)
	);

	// a result only follows a finish in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without a finish transaction");

	// result strobe lasts one cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	// empty region reports zeros
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (kept_count == 13'd0)) |->
		((chosen_depth == 20'd0) && (mean_depth == 20'd0)))
		else $error("empty region gave a nonzero statistic");

	// min never above max for a nonempty region
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (kept_count != 13'd0)) |-> (least_depth <= greatest_depth))
		else $error("least depth above greatest depth");

endmodule

FILE: bench/tb_region_depth_statistics.sv
// self-checking bench for region_depth_statistics: directed table, then random regions
// depends on rtl/core/rds_pkg.sv and rtl/core/region_depth_statistics.sv
`timescale 1ns / 1ps

module tb_region_depth_statistics;

	typedef struct {
		logic [19:0] chosen;
		logic [19:0] mean;
		logic [15:0] least;
		logic [15:0] greatest;
		logic [12:0] count;
		logic        ovf;
	} region_stats_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_FINISH} row_kind_t;

	typedef struct {
		row_kind_t     kind;
		logic [1:0]    idx;
		logic [16:0]   value;
		bit            typed;
		region_stats_t stats;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        mode;
	logic [15:0] depth_sample;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [16:0] cfg_data;
	logic        result_valid;
	logic [19:0] chosen_depth;
	logic [19:0] mean_depth;
	logic [15:0] least_depth;
	logic [15:0] greatest_depth;
	logic [12:0] kept_count;
	logic        overflowed;

	region_depth_statistics dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .mode(mode), .depth_sample(depth_sample),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .chosen_depth(chosen_depth),
		.mean_depth(mean_depth), .least_depth(least_depth),
		.greatest_depth(greatest_depth), .kept_count(kept_count),
		.overflowed(overflowed)
	);

	// shadow copy of the configuration and the open region
	logic [15:0]   lower_q;
	logic [16:0]   upper_q;
	logic [2:0]    algo_q;
	logic [15:0]   kept_q[$];
	logic [27:0]   sum_q;
	logic          dropped_q;
	region_stats_t pending_stats[$];
	int            errors;
	int            results_seen;
	int            regions_sent;
	int            samples_sent;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// generous watchdog, far beyond the slowest legal run
	initial begin
		#40_000_000;
		$display("tb_region_depth_statistics NOT OK");
		$finish;
	end

	// fold one sample into the shadow region
	function automatic void absorb_sample(logic [15:0] px);
		if (px > lower_q && {1'b0, px} < upper_q) begin
			if (kept_q.size() < rds_pkg::MAX_SAMPLES) begin
				kept_q.insert(kept_q.size(), px);
				sum_q += 28'(px);
			end else begin
				dropped_q = 1'b1;
			end
		end
	endfunction

	// statistics of the open region; clears it afterwards
	function automatic region_stats_t close_region();
		region_stats_t r;
		logic [15:0]   sorted[$];
		int            n, i, run, best_run;
		logic [15:0]   best_val, lo, hi;
		logic [31:0]   mean;
		n = kept_q.size();
		r.ovf = dropped_q;
		r.count = 13'(n);
		if (n == 0) begin
			r.chosen = '0;
			r.mean = '0;
			r.least = '0;
			r.greatest = '0;
		end else begin
			sorted = kept_q;
			sorted.sort();
			lo = sorted[0];
			hi = sorted[n-1];
			mean = ({4'd0, sum_q} << rds_pkg::Q_SHIFT) / n;
			// mode: longest run in sorted order, first one wins ties
			best_val = sorted[0];
			best_run = 0;
			i = 0;
			while (i < n) begin
				run = 0;
				while (i + run < n && sorted[i+run] == sorted[i])
					run++;
				if (run > best_run) begin
					best_run = run;
					best_val = sorted[i];
				end
				i += run;
			end
			r.mean = mean[19:0];
			r.least = lo;
			r.greatest = hi;
			case (algo_q)
				rds_pkg::ALGO_MEAN: r.chosen = mean[19:0];
				rds_pkg::ALGO_MIN:  r.chosen = {lo, 4'd0};
				rds_pkg::ALGO_MAX:  r.chosen = {hi, 4'd0};
				rds_pkg::ALGO_MODE: r.chosen = {best_val, 4'd0};
				default:            r.chosen = {sorted[n/2], 4'd0};
			endcase
		end
		kept_q.delete();
		sum_q = '0;
		dropped_q = 1'b0;
		return r;
	endfunction

	// result checker: the strobe cannot be held off, so just compare on every edge
	always @(posedge clk) begin
		region_stats_t e;
		if (arst_n && result_valid) begin
			results_seen++;
			if (pending_stats.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, chosen %0d count %0d", $time,
					chosen_depth, kept_count);
			end else begin
				e = pending_stats.pop_front();
				if (chosen_depth !== e.chosen) begin
					errors++;
					$display("%0t: chosen_depth exp %0d got %0d", $time, e.chosen, chosen_depth);
				end
				if (mean_depth !== e.mean) begin
					errors++;
					$display("%0t: mean_depth exp %0d got %0d", $time, e.mean, mean_depth);
				end
				if (least_depth !== e.least) begin
					errors++;
					$display("%0t: least_depth exp %0d got %0d", $time, e.least, least_depth);
				end
				if (greatest_depth !== e.greatest) begin
					errors++;
					$display("%0t: greatest_depth exp %0d got %0d", $time, e.greatest,
						greatest_depth);
				end
				if (kept_count !== e.count) begin
					errors++;
					$display("%0t: kept_count exp %0d got %0d", $time, e.count, kept_count);
				end
				if (overflowed !== e.ovf) begin
					errors++;
					$display("%0t: overflowed exp %0d got %0d", $time, e.ovf, overflowed);
				end
			end
		end
	end

	// present one transaction and hold it until the block takes it
	task automatic issue(input logic m, input logic [15:0] px, input bit typed,
			input region_stats_t typed_stats);
		region_stats_t r;
		start <= 1'b1;
		mode <= m;
		depth_sample <= px;
		do @(posedge clk); while (busy);
		if (m) begin
			r = close_region();
			pending_stats.insert(pending_stats.size(), typed ? typed_stats : r);
			regions_sent++;
		end else begin
			absorb_sample(px);
			samples_sent++;
		end
	endtask

	// random gap after a transaction, mostly none, a few long
	task automatic sender_gap();
		int p, g;
		p = $urandom_range(99);
		g = (p < 65) ? 0 : (p < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// drain every pending result, then let the block settle
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_stats.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one register write, then cfg_we is dropped again before anything else drives the port
	task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rds_pkg::CFG_LOWER: lower_q = value[15:0];
			rds_pkg::CFG_UPPER: upper_q = value;
			default:            algo_q = value[2:0];
		endcase
		@(posedge clk);
	endtask

	// one random region; mode scans grow with the square of the region size, so keep regions small
	task automatic random_region(input bit narrow);
		int n;
		region_stats_t none;
		logic [15:0] base;
		none = '{default: '0};
		n = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
		base = 16'($urandom);
		repeat (n) begin
			if (narrow)
				issue(1'b0, base + 16'($urandom_range(3)), 1'b0, none);
			else
				issue(1'b0, 16'($urandom), 1'b0, none);
			sender_gap();
		end
		issue(1'b1, 16'($urandom), 1'b0, none);
		sender_gap();
	endtask

	stim_row_t     directed[$];
	region_stats_t zero_stats;
	region_stats_t pair_stats;

	initial begin
		int i, phase, lim;
		arst_n = 1'b0;
		start = 1'b0;
		mode = 1'b0;
		depth_sample = '0;
		cfg_we = 1'b0;
		cfg_index = rds_pkg::CFG_LOWER;
		cfg_data = '0;
		lower_q = 16'd0;
		upper_q = 17'd65535;
		algo_q = rds_pkg::ALGO_MEDIAN;
		sum_q = '0;
		dropped_q = 1'b0;
		errors = 0;
		results_seen = 0;
		regions_sent = 0;
		samples_sent = 0;
		zero_stats = '{default: '0};
		// samples 1 and 65534 kept, median picks the upper one
		pair_stats = '{20'd1048544, 20'd524280, 16'd1, 16'd65534, 13'd2, 1'b0};

		// empty region right after reset, then the threshold edges under median
		directed = '{
			'{ROW_FINISH, rds_pkg::CFG_LOWER, 17'd0,     1, zero_stats},
			'{ROW_SAMPLE, rds_pkg::CFG_LOWER, 17'd0,     0, zero_stats},
			'{ROW_SAMPLE, rds_pkg::CFG_LOWER, 17'd65535, 0, zero_stats},
			'{ROW_SAMPLE, rds_pkg::CFG_LOWER, 17'd1,     0, zero_stats},
			'{ROW_SAMPLE, rds_pkg::CFG_LOWER, 17'd65534, 0, zero_stats},
			'{ROW_FINISH, rds_pkg::CFG_LOWER, 17'd0,     1, pair_stats},
			'{ROW_CFG,    rds_pkg::CFG_ALGO,  17'(rds_pkg::ALGO_MEAN), 0, zero_stats},
			'{ROW_SAMPLE, rds_pkg::CFG_LOWER, 17'd5,     0, zero_stats},
			'{ROW_SAMPLE, rds_pkg::CFG_LOWER, 17'd6,     0, zero_stats},
			'{ROW_FINISH, rds_pkg::CFG_LOWER, 17'd0,     0, zero_stats},
			'{ROW_CFG,    rds_pkg::CFG_ALGO,  17'(rds_pkg::ALGO_MIN), 0, zero_stats},
			'{ROW_SAMPLE, rds_pkg::CFG_LOWER, 17'd7,     0, zero_stats},
			'{ROW_SAMPLE, rds_pkg::CFG_LOWER, 17'd3,     0, zero_stats},
			'{ROW_FINISH, rds_pkg::CFG_LOWER, 17'd0,     0, zero_stats},
			'{ROW_CFG,    rds_pkg::CFG_ALGO,  17'(rds_pkg::ALGO_MAX), 0, zero_stats},
			'{ROW_SAMPLE, rds_pkg::CFG_LOWER, 17'd7,     0, zero_stats},
			'{ROW_SAMPLE, rds_pkg::CFG_LOWER, 17'd3,     0, zero_stats},
			'{ROW_FINISH, rds_pkg::CFG_LOWER, 17'd0,     0, zero_stats},
			// mode with a tie: the smaller value wins
			'{ROW_CFG,    rds_pkg::CFG_ALGO,  17'(rds_pkg::ALGO_MODE), 0, zero_stats},
			'{ROW_SAMPLE, rds_pkg::CFG_LOWER, 17'd9,     0, zero_stats},
			'{ROW_SAMPLE, rds_pkg::CFG_LOWER, 17'd4,     0, zero_stats},
			'{ROW_SAMPLE, rds_pkg::CFG_LOWER, 17'd9,     0, zero_stats},
			'{ROW_SAMPLE, rds_pkg::CFG_LOWER, 17'd4,     0, zero_stats},
			'{ROW_FINISH, rds_pkg::CFG_LOWER, 17'd0,     0, zero_stats},
			// unused code falls back to median; upper bound 65536 keeps 65535
			'{ROW_CFG,    rds_pkg::CFG_ALGO,  17'd7,     0, zero_stats},
			'{ROW_CFG,    rds_pkg::CFG_UPPER, 17'd65536, 0, zero_stats},
			'{ROW_CFG,    rds_pkg::CFG_LOWER, 17'd65534, 0, zero_stats},
			'{ROW_SAMPLE, rds_pkg::CFG_LOWER, 17'd65535, 0, zero_stats},
			'{ROW_SAMPLE, rds_pkg::CFG_LOWER, 17'd65534, 0, zero_stats},
			'{ROW_FINISH, rds_pkg::CFG_LOWER, 17'd0,     0, zero_stats},
			// window closed entirely
			'{ROW_CFG,    rds_pkg::CFG_UPPER, 17'd0,     0, zero_stats},
			'{ROW_SAMPLE, rds_pkg::CFG_LOWER, 17'd100,   0, zero_stats},
			'{ROW_FINISH, rds_pkg::CFG_LOWER, 17'd0,     0, zero_stats}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k]) begin
			case (directed[k].kind)
				ROW_CFG: begin
					wait_idle();
					write_reg(directed[k].idx, directed[k].value);
				end
				ROW_SAMPLE: issue(1'b0, directed[k].value[15:0], 1'b0, zero_stats);
				default: issue(1'b1, 16'hffff, directed[k].typed, directed[k].stats);
			endcase
			sender_gap();
		end

		// random phases, each with fresh configuration written while idle
		for (phase = 0; phase < 15; phase++) begin
			wait_idle();
			case ($urandom_range(5))
				0: write_reg(rds_pkg::CFG_LOWER, 17'd0);
				1: write_reg(rds_pkg::CFG_LOWER, 17'd65535);
				default: write_reg(rds_pkg::CFG_LOWER, 17'($urandom_range(0, 20000)));
			endcase
			case ($urandom_range(5))
				0: write_reg(rds_pkg::CFG_UPPER, 17'd65536);
				1: write_reg(rds_pkg::CFG_UPPER, 17'($urandom_range(0, 65536)));
				default: write_reg(rds_pkg::CFG_UPPER, 17'($urandom_range(40000, 65536)));
			endcase
			write_reg(rds_pkg::CFG_ALGO, 17'($urandom_range(7)));
			lim = $urandom_range(4, 10);
			for (i = 0; i < lim; i++) begin
				random_region($urandom_range(1) == 1);
				// hold off until the block has delivered everything
				if ($urandom_range(7) == 0)
					wait_idle();
			end
		end

		start <= 1'b0;
		i = 0;
		while (pending_stats.size() != 0 && i < 100000) begin
			@(posedge clk);
			i++;
		end
		repeat (50) @(posedge clk);
		if (pending_stats.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, pending_stats.size());
		end
		$display("covered %0d samples in %0d regions, %0d results checked, all statistic codes",
			samples_sent, regions_sent, results_seen);
		if (errors == 0)
			$display("tb_region_depth_statistics OK");
		else
			$display("tb_region_depth_statistics NOT OK");
		$finish;
	end

endmodule

FILE: region_depth_statistics.f
rtl/core/rds_pkg.sv
rtl/core/rds_datapath.sv
rtl/core/rds_ctrl.sv
rtl/core/region_depth_statistics.sv
bench/tb_region_depth_statistics.sv
